FILE: hw/rtl/eti_pkg.sv
// Shared types and constants for the escape-time fractal iterator.
// No dependencies; every other file of the block imports this package.
package eti_pkg;

   localparam int FRAC_BITS   = 28;
   localparam int COUNT_BITS  = 16;
   localparam int COORD_BITS  = 32;
   localparam int PROD_BITS   = 2 * COORD_BITS;
   localparam int RATIO_BITS  = 17;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int DIV_STEPS   = RATIO_BITS;
   localparam int STEP_BITS   = $clog2(DIV_STEPS + 1);

   // |z|^2 threshold of 4 in Q(2*FRAC_BITS)
   localparam logic [PROD_BITS-1:0] FOUR_MAG = PROD_BITS'(4) << (2 * FRAC_BITS);
   localparam logic signed [PROD_BITS-1:0] SAT_MAX =
      PROD_BITS'((64'd1 << (FRAC_BITS + 3)) - 64'd1);
   localparam logic signed [PROD_BITS-1:0] SAT_MIN = -SAT_MAX - PROD_BITS'(1);

   localparam int ADDR_BITS = 4;
   localparam logic [1:0] REG_LIMIT     = 2'd0;
   localparam logic [1:0] REG_SWAP      = 2'd1;
   localparam logic [1:0] REG_DIVERGING = 2'd2;
   localparam logic [COUNT_BITS-1:0] LIMIT_RESET = COUNT_BITS'(256);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] c_re;
      logic signed [COORD_BITS-1:0] c_im;
      logic signed [COORD_BITS-1:0] z_re;
      logic signed [COORD_BITS-1:0] z_im;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] iteration_count;
      logic [RATIO_BITS-1:0] escape_ratio;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] limit;
      logic                  swap;
      logic                  diverging;
   } cfg_type;

   typedef struct packed {
      logic                  start;
      logic [COUNT_BITS-1:0] count;
      logic [COUNT_BITS-1:0] limit;
   } div_in_type;

   typedef struct packed {
      logic                  done;
      logic [RATIO_BITS-1:0] ratio;
   } div_out_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_TEST,
      BK_DIV
   } back_state_type;

endpackage

FILE: hw/rtl/eti_front.sv
// Front end: takes items from the request channel, applies the c/z swap
// and hands them to the point queue. Depends on eti_pkg.
module eti_front import eti_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  cfg_type cfg,
   input  logic    queue_full,
   output logic    push,
   output req_type push_data
);

   logic    valid_ff, valid_in;
   req_type point_ff, point_in;
   logic    accept;

   assign push      = valid_ff && !queue_full;
   assign push_data = point_ff;
   assign req_stall = valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      point_in = point_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
         point_in = req_data;
         // Julia plotting: exchange c and z
         if (cfg.swap) begin
            point_in.c_re = req_data.z_re;
            point_in.c_im = req_data.z_im;
            point_in.z_re = req_data.c_re;
            point_in.z_im = req_data.c_im;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      point_ff <= point_in;
   end

endmodule

FILE: hw/rtl/eti_queue.sv
// Short queue of points between the front end and the iteration engine.
// Depends on eti_pkg.
module eti_queue import eti_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  req_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output req_type pop_data
);

   req_type               entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  fill_ff, fill_in;

   assign full      = (fill_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QPTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QPTR_BITS'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/eti_div.sv
// Restoring divider for the escape ratio: floor(count * 2^16 / limit),
// one quotient bit per cycle. Depends on eti_pkg.
module eti_div import eti_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_in_type  div_in,
   output div_out_type div_out
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [RATIO_BITS-1:0] rem_ff, rem_in;
   logic [RATIO_BITS-1:0] quo_ff, quo_in;
   logic [COUNT_BITS-1:0] limit_ff, limit_in;
   logic [STEP_BITS-1:0]  steps_ff, steps_in;
   logic                  ge;
   logic [RATIO_BITS-1:0] rem_sub;

   assign ge      = (rem_ff >= RATIO_BITS'(limit_ff));
   assign rem_sub = ge ? rem_ff - RATIO_BITS'(limit_ff) : rem_ff;

   assign div_out.done  = done_ff;
   assign div_out.ratio = quo_ff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      limit_in = limit_ff;
      steps_in = steps_ff;
      if (div_in.start) begin
         limit_in = div_in.limit;
         rem_in   = RATIO_BITS'(div_in.count);
         quo_in   = '0;
         steps_in = STEP_BITS'(DIV_STEPS);
         // zero limit reports a ratio of zero
         busy_in  = (div_in.limit != '0);
         done_in  = (div_in.limit == '0);
      end else if (busy_ff) begin
         // remainder stays below limit, so the shift cannot overflow
         rem_in   = {rem_sub[RATIO_BITS-2:0], 1'b0};
         quo_in   = {quo_ff[RATIO_BITS-2:0], ge};
         steps_in = steps_ff - STEP_BITS'(1);
         if (steps_ff == STEP_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      limit_ff <= limit_in;
      steps_ff <= steps_in;
   end

endmodule

FILE: hw/rtl/eti_back.sv
// Iteration engine: runs z = z*z + c on one point, then the ratio divide,
// and holds the result in the output register. Depends on eti_pkg, eti_div.
module eti_back import eti_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    q_valid,
   input  req_type q_data,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   function automatic logic signed [COORD_BITS-1:0] sat_coord(
      input logic signed [PROD_BITS-1:0] v
   );
      logic signed [PROD_BITS-1:0] r;
      r = v;
      if (v > SAT_MAX) begin
         r = SAT_MAX;
      end else if (v < SAT_MIN) begin
         r = SAT_MIN;
      end
      return r[COORD_BITS-1:0];
   endfunction

   back_state_type state_ff, state_in;

   logic signed [COORD_BITS-1:0] c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic signed [COORD_BITS-1:0] z_re_ff, z_re_in, z_im_ff, z_im_in;
   logic signed [PROD_BITS-1:0]  rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_data_ff, rsp_data_in;

   logic signed [PROD_BITS-1:0]  prod_rr, prod_ii, prod_ri;
   logic [PROD_BITS-1:0]         mag;
   logic                         go;
   logic signed [PROD_BITS-1:0]  next_re, next_im;
   div_in_type                   div_in;
   div_out_type                  div_out;

   assign prod_rr = z_re_ff * z_re_ff;
   assign prod_ii = z_im_ff * z_im_ff;
   assign prod_ri = z_re_ff * z_im_ff;

   // squares are non-negative and at most 2^62 each, so the sum fits unsigned
   assign mag     = $unsigned(rr_ff) + $unsigned(ii_ff);
   assign go      = cfg.diverging ? (mag > FOUR_MAG) : (mag < FOUR_MAG);
   assign next_re = ((rr_ff - ii_ff) >>> FRAC_BITS) + PROD_BITS'(c_re_ff);
   assign next_im = (ri_ff >>> (FRAC_BITS - 1)) + PROD_BITS'(c_im_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   eti_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_in),
      .div_out (div_out)
   );

   always_comb begin
      state_in     = state_ff;
      c_re_in      = c_re_ff;
      c_im_in      = c_im_ff;
      z_re_in      = z_re_ff;
      z_im_in      = z_im_ff;
      rr_in        = rr_ff;
      ii_in        = ii_ff;
      ri_in        = ri_ff;
      count_in     = count_ff;
      pop          = 1'b0;
      div_in.start = 1'b0;
      div_in.count = count_ff;
      div_in.limit = cfg.limit;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               pop      = 1'b1;
               c_re_in  = q_data.c_re;
               c_im_in  = q_data.c_im;
               z_re_in  = q_data.z_re;
               z_im_in  = q_data.z_im;
               count_in = '0;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            if (count_ff >= cfg.limit) begin
               div_in.start = 1'b1;
               state_in     = BK_DIV;
            end else begin
               rr_in    = prod_rr;
               ii_in    = prod_ii;
               ri_in    = prod_ri;
               state_in = BK_TEST;
            end
         end
         BK_TEST: begin
            if (go) begin
               z_re_in  = sat_coord(next_re);
               z_im_in  = sat_coord(next_im);
               count_in = count_ff + COUNT_BITS'(1);
               state_in = BK_MUL;
            end else begin
               div_in.start = 1'b1;
               state_in     = BK_DIV;
            end
         end
         BK_DIV: begin
            // hold until the divider is done and the output register is free
            if (div_out.done && (!rsp_valid_ff || !rsp_stall)) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.iteration_count = count_ff;
               rsp_data_in.escape_ratio    = div_out.ratio;
               state_in                    = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      c_re_ff     <= c_re_in;
      c_im_ff     <= c_im_in;
      z_re_ff     <= z_re_in;
      z_im_ff     <= z_im_in;
      rr_ff       <= rr_in;
      ii_ff       <= ii_in;
      ri_ff       <= ri_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

FILE: hw/rtl/escape_time_fractal_iterator.sv
// Escape-time fractal iterator, top level: register file, front end, queue, engine.
// Path from accept to result valid: front register and queue, then for each iteration
// a multiply state and a test-and-update state, a final limit check in the multiply state
// or the magnitude test ending the loop, the divider's 17 steps, the output register load.
// One item is iterated at a time, and a result stall holds it in the output register.
// Synchronous active-high reset: limit 256, swap off, converging.
module escape_time_fractal_iterator import eti_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);

   cfg_type    cfg_ff, cfg_in;
   logic       reg_write;
   logic [1:0] reg_index;
   logic       queue_full, push, pop, q_valid;
   req_type    push_data, q_data;

   assign pready    = 1'b1;
   assign reg_write = psel && penable && pwrite && pready;
   assign reg_index = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (reg_write) begin
         case (reg_index)
            REG_LIMIT:     cfg_in.limit     = pwdata[COUNT_BITS-1:0];
            REG_SWAP:      cfg_in.swap      = pwdata[0];
            REG_DIVERGING: cfg_in.diverging = pwdata[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_LIMIT:     prdata = 32'(cfg_ff.limit);
         REG_SWAP:      prdata = 32'(cfg_ff.swap);
         REG_DIVERGING: prdata = 32'(cfg_ff.diverging);
         default:       prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit     <= LIMIT_RESET;
         cfg_ff.swap      <= 1'b0;
         cfg_ff.diverging <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   eti_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   eti_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   eti_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // the ratio is count/limit in Q1.16 and can never pass one
   a_ratio_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.escape_ratio <= RATIO_BITS'(65536)))
      else $error("escape ratio above one");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.iteration_count <= cfg_ff.limit))
      else $error("iteration count beyond limit");

   a_ratio_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (cfg_ff.limit != '0)) |->
         ((rsp_data.escape_ratio == RATIO_BITS'(65536)) ==
          (rsp_data.iteration_count == cfg_ff.limit)))
      else $error("full ratio does not match count at limit");

endmodule
